FILE: rtl/mi_pkg.sv
// Shared types and constants of the modular inverse block.
package mi_pkg;

    localparam int MI_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_REDUCE,
        ST_FINISH
    } mi_state_t;

    typedef struct packed {
        logic start;
    } mi_step_ctl_t;

    typedef struct packed {
        logic done;
    } mi_step_sts_t;

endpackage

FILE: rtl/mi_if.sv
// Valid/ready channel interfaces for operand items and result items.
interface mi_in_if
    import mi_pkg::*;
#(
    parameter int WIDTH = MI_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-2:0] value;
    logic [WIDTH-2:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface mi_out_if
    import mi_pkg::*;
#(
    parameter int WIDTH = MI_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-2:0] inverse;
    logic             invertible;
    logic [WIDTH-2:0] common_divisor;

    modport source (output valid, output inverse, output invertible, output common_divisor,
                    input ready);
    modport sink   (input valid, input inverse, input invertible, input common_divisor,
                    output ready);
endinterface

FILE: rtl/mi_step.sv
// Bit-serial Euclid step: restoring division with a shift-and-add quotient product.
module mi_step
    import mi_pkg::*;
#(
    parameter int WIDTH = MI_WIDTH
)(
    input  logic             clk,
    input  logic             rst_n,
    input  mi_step_ctl_t     ctl,
    input  logic [WIDTH-2:0] dividend,
    input  logic [WIDTH-2:0] divisor,
    input  logic [WIDTH-2:0] coef,
    output logic [WIDTH-2:0] rem,
    output logic [WIDTH-2:0] prod,
    output mi_step_sts_t     sts
);
    localparam int F  = WIDTH - 1;
    localparam int CW = $clog2(F);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [F-1:0]  dvd_reg, dvd_next;
    logic [F-1:0]  rem_reg, rem_next;
    logic [F-1:0]  acc_reg, acc_next;
    logic [F:0]    trial;
    logic [F:0]    diff;
    logic          qbit;

    // One quotient bit per cycle, most significant first.
    assign trial = {rem_reg, dvd_reg[F-1]};
    assign diff  = trial - {1'b0, divisor};
    assign qbit  = ~diff[F];

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        if (ctl.start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            dvd_next  = dividend;
            rem_next  = '0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[F-2:0], 1'b0};
            rem_next = qbit ? diff[F-1:0] : trial[F-1:0];
            acc_next = {acc_reg[F-2:0], 1'b0} + (qbit ? coef : '0);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(F - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    assign rem      = rem_reg;
    assign prod     = acc_reg;
    assign sts.done = done_reg;
endmodule

FILE: rtl/modular_inverse.sv
// Modular inverse by the extended Euclidean algorithm, one item at a time.
// Each operand item (value, modulus) yields one result item with the gcd, an
// invertible flag and the inverse of value modulo modulus in 0..modulus-1 (0
// when the gcd is not 1 or the modulus is 0). Every Euclid step runs through a
// bit-serial divider that produces one quotient bit and one partial product of
// the coefficient per cycle. The remainder chain is at most about 46 steps long
// for WIDTH = 32. A new item is taken once the previous one has been moved into
// the output register, which holds it until the sink takes it.
module modular_inverse
    import mi_pkg::*;
#(
    parameter int WIDTH = MI_WIDTH
)(
    input  logic     clk,
    input  logic     rst_n,
    mi_in_if.sink    operands,
    mi_out_if.source result
);
    localparam int F = WIDTH - 1;

    mi_state_t    state_reg, state_next;
    logic [F-1:0] rp_reg, rp_next;
    logic [F-1:0] rc_reg, rc_next;
    logic [F-1:0] up_reg, up_next;
    logic [F-1:0] uc_reg, uc_next;
    logic [F-1:0] m_reg, m_next;
    logic         neg_p_reg, neg_p_next;
    logic         neg_c_reg, neg_c_next;
    logic         out_valid_reg, out_valid_next;
    logic [F-1:0] inv_reg, inv_next;
    logic         one_reg, one_next;
    logic [F-1:0] gcd_reg, gcd_next;
    logic         out_load;

    mi_step_ctl_t step_ctl;
    mi_step_sts_t step_sts;
    logic [F-1:0] step_rem;
    logic [F-1:0] step_prod;

    mi_step #(
        .WIDTH (WIDTH)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (step_ctl),
        .dividend (rp_reg),
        .divisor  (rc_reg),
        .coef     (uc_reg),
        .rem      (step_rem),
        .prod     (step_prod),
        .sts      (step_sts)
    );

    assign operands.ready = (state_reg == ST_IDLE);
    assign out_load       = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        rc_next        = rc_reg;
        up_next        = up_reg;
        uc_next        = uc_reg;
        m_next         = m_reg;
        neg_p_next     = neg_p_reg;
        neg_c_next     = neg_c_reg;
        step_ctl.start = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;
        inv_next       = inv_reg;
        one_next       = one_reg;
        gcd_next       = gcd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (operands.valid)
                begin
                    rp_next    = operands.modulus;
                    rc_next    = operands.value;
                    up_next    = '0;
                    uc_next    = F'(1);
                    m_next     = operands.modulus;
                    neg_p_next = 1'b0;
                    neg_c_next = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (rc_reg == '0)
                begin
                    state_next = ST_REDUCE;
                end
                else
                begin
                    step_ctl.start = 1'b1;
                    state_next     = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (step_sts.done)
                begin
                    rp_next    = rc_reg;
                    rc_next    = step_rem;
                    up_next    = uc_reg;
                    uc_next    = up_reg + step_prod;
                    neg_p_next = neg_c_reg;
                    neg_c_next = !neg_c_reg;
                    state_next = ST_CHECK;
                end
            end
            ST_REDUCE:
            begin
                // The final coefficient never exceeds a nonzero modulus, so one
                // conditional subtraction reduces it.
                if (up_reg >= m_reg)
                begin
                    up_next = up_reg - m_reg;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    gcd_next       = rp_reg;
                    one_next       = (rp_reg == F'(1));
                    if (rp_reg != F'(1) || m_reg == '0)
                    begin
                        inv_next = '0;
                    end
                    else if (neg_p_reg && up_reg != '0)
                    begin
                        inv_next = m_reg - up_reg;
                    end
                    else
                    begin
                        inv_next = up_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg    <= rp_next;
        rc_reg    <= rc_next;
        up_reg    <= up_next;
        uc_reg    <= uc_next;
        m_reg     <= m_next;
        neg_p_reg <= neg_p_next;
        neg_c_reg <= neg_c_next;
        inv_reg   <= inv_next;
        one_reg   <= one_next;
        gcd_reg   <= gcd_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.inverse        = inv_reg;
    assign result.invertible     = one_reg;
    assign result.common_divisor = gcd_reg;
endmodule

FILE: rtl/mi_checker.sv
// Port-level assertions for the modular inverse block and their binding.
module mi_checker
    import mi_pkg::*;
#(
    parameter int WIDTH = MI_WIDTH
)(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [WIDTH-2:0] inverse,
    input logic             invertible,
    input logic [WIDTH-2:0] common_divisor
);
    // Taking an item closes the operand channel in the cycle after it is taken.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("operand channel stayed open after an item was taken");

    a_flag_matches_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (invertible == (common_divisor == (WIDTH-1)'(1))))
        else $error("invertible flag disagrees with the gcd");

    a_no_inverse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !invertible |-> inverse == '0)
        else $error("nonzero inverse for a non-invertible item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(inverse) && $stable(common_divisor))
        else $error("result item changed while stalled");
endmodule

bind modular_inverse mi_checker #(
    .WIDTH (WIDTH)
) u_mi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (operands.valid),
    .in_ready       (operands.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .inverse        (result.inverse),
    .invertible     (result.invertible),
    .common_divisor (result.common_divisor)
);

FILE: verif/modular_inverse_tb.sv
// Self-checking testbench of the modular inverse block: directed table, then random operands.
module modular_inverse_tb
    import mi_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = MI_WIDTH - 1;
    localparam logic [FW-1:0] FIELD_MAX = '1;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES = 5000;
    localparam int TAIL_CYCLES = 2000;
    localparam int LIMIT_NS = 10_000_000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [FW-1:0] inverse;
        logic          invertible;
        logic [FW-1:0] common_divisor;
    } inv_result_t;

    typedef struct packed {
        logic [FW-1:0] value;
        logic [FW-1:0] modulus;
        inv_result_t   want;
    } awaited_t;

    typedef struct packed {
        logic [FW-1:0] value;
        logic [FW-1:0] modulus;
        logic          typed;
        logic [FW-1:0] inverse;
        logic          invertible;
        logic [FW-1:0] common_divisor;
    } operand_row_t;

    // Rows with typed set carry their answer; the rest go through the predictor.
    operand_row_t directed_rows [22] = '{
        '{31'd0, 31'd0, 1'b1, 31'd0, 1'b0, 31'd0},
        '{31'd0, 31'd1, 1'b1, 31'd0, 1'b1, 31'd1},
        '{31'd1, 31'd1, 1'b1, 31'd0, 1'b1, 31'd1},
        '{31'd1, 31'd0, 1'b1, 31'd0, 1'b1, 31'd1},
        '{31'd5, 31'd0, 1'b1, 31'd0, 1'b0, 31'd5},
        '{31'd0, 31'd7, 1'b1, 31'd0, 1'b0, 31'd7},
        '{31'd0, FIELD_MAX, 1'b1, 31'd0, 1'b0, FIELD_MAX},
        '{FIELD_MAX, 31'd0, 1'b1, 31'd0, 1'b0, FIELD_MAX},
        '{FIELD_MAX, FIELD_MAX, 1'b1, 31'd0, 1'b0, FIELD_MAX},
        '{31'd1, FIELD_MAX, 1'b1, 31'd1, 1'b1, 31'd1},
        '{FIELD_MAX, 31'd1, 1'b1, 31'd0, 1'b1, 31'd1},
        '{31'd2, 31'd1, 1'b1, 31'd0, 1'b1, 31'd1},
        '{31'd10, 31'd4, 1'b1, 31'd0, 1'b0, 31'd2},
        '{31'd6, 31'd9, 1'b1, 31'd0, 1'b0, 31'd3},
        '{31'd2147483646, FIELD_MAX, 1'b0, 31'd0, 1'b0, 31'd0},
        '{31'd3, 31'd7, 1'b0, 31'd0, 1'b0, 31'd0},
        '{31'd17, 31'd3120, 1'b0, 31'd0, 1'b0, 31'd0},
        '{31'd100, 31'd7, 1'b0, 31'd0, 1'b0, 31'd0},
        '{31'd1134903170, 31'd1836311903, 1'b0, 31'd0, 1'b0, 31'd0},
        '{31'd1836311903, 31'd1134903170, 1'b0, 31'd0, 1'b0, 31'd0},
        '{31'd1073741824, FIELD_MAX, 1'b0, 31'd0, 1'b0, 31'd0},
        '{31'd65537, 31'd3120, 1'b0, 31'd0, 1'b0, 31'd0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mi_in_if  operand_bus ();
    mi_out_if result_bus ();

    modular_inverse uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operand_bus),
        .result   (result_bus)
    );

    awaited_t awaited_results [$];
    bit idle_enable = 1'b1;
    bit hold_request = 1'b0;
    int mismatches = 0;
    int items_sent = 0;
    int invertible_seen = 0;
    int singular_seen = 0;
    int stall_cycles = 0;

    always #1 clk = ~clk;

    // Extended Euclid on (modulus, value) with coefficient magnitudes of alternating sign.
    function automatic inv_result_t euclid_inverse(logic [FW-1:0] value, logic [FW-1:0] modulus);
        logic [63:0] r_prev, r_cur, r_next, quot, c_prev, c_cur, c_next, mag;
        logic sign_prev, sign_cur;
        inv_result_t res;
        r_prev = 64'(modulus);
        r_cur = 64'(value);
        c_prev = 64'd0;
        c_cur = 64'd1;
        sign_prev = 1'b0;
        sign_cur = 1'b0;
        while (r_cur != 64'd0)
        begin
            quot = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            c_next = c_prev + quot * c_cur;
            r_prev = r_cur;
            r_cur = r_next;
            c_prev = c_cur;
            c_cur = c_next;
            sign_prev = sign_cur;
            sign_cur = ~sign_cur;
        end
        res.common_divisor = r_prev[FW-1:0];
        res.invertible = (r_prev == 64'd1);
        res.inverse = '0;
        if (res.invertible && modulus != '0)
        begin
            mag = c_prev % 64'(modulus);
            res.inverse = (sign_prev && mag != 64'd0) ? FW'(64'(modulus) - mag) : mag[FW-1:0];
        end
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return $urandom_range(1, 3);
        if (pick < 19)
            return $urandom_range(4, 12);
        return $urandom_range(40, 200);
    endfunction

    task automatic draw_operands(output logic [FW-1:0] value, output logic [FW-1:0] modulus);
        int unsigned kind, factor;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            value = FW'($urandom());
            modulus = FW'($urandom());
        end
        else if (kind < 60)
        begin
            value = FW'($urandom_range(0, 1000));
            modulus = FW'($urandom_range(1, 1000));
        end
        else if (kind < 72)
        begin
            // A shared factor makes all of these non-invertible.
            factor = $urandom_range(2, 5000);
            value = FW'($urandom_range(0, FIELD_MAX / factor) * factor);
            modulus = FW'($urandom_range(1, FIELD_MAX / factor) * factor);
        end
        else if (kind < 82)
        begin
            value = FW'($urandom());
            modulus = FW'($urandom_range(1, 100000));
        end
        else if (kind < 90)
        begin
            value = FW'($urandom());
            modulus = FIELD_MAX;
        end
        else if (kind < 95)
        begin
            value = FW'(65537);
            modulus = FW'($urandom());
        end
        else
        begin
            value = ($urandom_range(0, 1) == 0) ? FW'($urandom_range(0, 1)) : FIELD_MAX;
            modulus = ($urandom_range(0, 2) == 0) ? FW'($urandom_range(0, 1)) : FW'($urandom());
        end
    endtask

    // Called in the time step of a rising edge; returns in the step where the item was taken.
    task automatic offer_item(input logic [FW-1:0] value, input logic [FW-1:0] modulus,
                              input logic typed, input inv_result_t typed_result);
        awaited_t entry;
        if (idle_enable && $urandom_range(0, 2) == 0)
        begin
            operand_bus.valid <= 1'b0;
            repeat (idle_gap()) @(posedge clk);
        end
        operand_bus.valid <= 1'b1;
        operand_bus.value <= value;
        operand_bus.modulus <= modulus;
        do @(posedge clk); while (!operand_bus.ready);
        entry.value = value;
        entry.modulus = modulus;
        entry.want = typed ? typed_result : euclid_inverse(value, modulus);
        awaited_results.insert(awaited_results.size(), entry);
        items_sent++;
    endtask

    task automatic drain_results();
        operand_bus.valid <= 1'b0;
        wait (awaited_results.size() == 0);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [FW-1:0] value, modulus;
        inv_result_t typed_result;
        operand_bus.valid = 1'b0;
        operand_bus.value = '0;
        operand_bus.modulus = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_result.inverse = directed_rows[i].inverse;
            typed_result.invertible = directed_rows[i].invertible;
            typed_result.common_divisor = directed_rows[i].common_divisor;
            offer_item(directed_rows[i].value, directed_rows[i].modulus,
                       directed_rows[i].typed, typed_result);
        end
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // A stretch without idling; the long hold-off falls inside it.
            idle_enable = !(i >= 100 && i < 200);
            if (i == 120)
                hold_request = 1'b1;
            if (i == 300)
                drain_results();
            draw_operands(value, modulus);
            offer_item(value, modulus, 1'b0, typed_result);
        end
        operand_bus.valid <= 1'b0;

        wait (awaited_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d operand items, %0d of them from the directed table.",
                 items_sent, $size(directed_rows));
        $display("%0d results were invertible, %0d were not; the input stalled for %0d cycles.",
                 invertible_seen, singular_seen, stall_cycles);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : result_sink
        result_bus.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_bus.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
                hold_request = 1'b0;
                result_bus.ready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 3) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (idle_gap()) @(posedge clk);
                result_bus.ready <= 1'b1;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watch_results
        awaited_t entry;
        logic bad;
        if (rst_n && operand_bus.valid && !operand_bus.ready)
            stall_cycles++;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (result_bus.invertible)
                invertible_seen++;
            else
                singular_seen++;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result: inverse %0d flag %0b gcd %0d",
                             result_bus.inverse, result_bus.invertible,
                             result_bus.common_divisor);
            end
            else
            begin
                entry = awaited_results.pop_front();
                bad = (result_bus.inverse !== entry.want.inverse)
                   || (result_bus.invertible !== entry.want.invertible)
                   || (result_bus.common_divisor !== entry.want.common_divisor);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $write("Mismatch for value %0d modulus %0d: expected inverse %0d ",
                               entry.value, entry.modulus, entry.want.inverse);
                        $display("flag %0b gcd %0d, got inverse %0d flag %0b gcd %0d",
                                 entry.want.invertible, entry.want.common_divisor,
                                 result_bus.inverse, result_bus.invertible,
                                 result_bus.common_divisor);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
